>>> design/srs_pkg.sv
// Package for the stereogram row shifter.
// Holds payload structs, the front-to-back work item and register indexes.
// No dependencies.
`timescale 1ns / 1ps
package srs_pkg;
   typedef struct packed {
      logic [7:0]  source_pixel;
      logic [15:0] depth;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
   } rsp_type;

   typedef struct packed {
      logic [7:0] source_pixel;
      logic [7:0] shift;
   } work_type;

   localparam logic [1:0] REG_EYE_DISTANCE = 2'd0;
   localparam logic [1:0] REG_FOCAL_DEPTH  = 2'd1;
   localparam logic [1:0] REG_ROW_WIDTH    = 2'd2;
endpackage

>>> design/srs_front.sv
// Front part: accepts a pixel and computes its clamped shift with a
// multiply followed by an 8-step restoring division. Uses srs_pkg.
`timescale 1ns / 1ps
module srs_front
   import srs_pkg::*;
#(
   parameter int MAX_SHIFT = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   input  logic [7:0]  eye_distance,
   input  logic [15:0] focal_depth,
   output logic        push_valid,
   input  logic        push_ready,
   output work_type    push_data
);
   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_MUL  = 2'd1;
   localparam logic [1:0] F_DIV  = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;
   localparam int LIM_INT = (MAX_SHIFT < 255) ? MAX_SHIFT : 255;
   localparam logic [7:0] LIM = 8'(LIM_INT);

   logic [1:0]  state_ff, state_in;
   logic [7:0]  src_ff, src_in;
   logic [15:0] depth_ff, depth_in;
   logic [23:0] rem_ff, rem_in;
   logic [7:0]  quot_ff, quot_in;
   logic [2:0]  step_ff, step_in;
   logic        zero_ff, zero_in;
   logic [23:0] trial;

   assign trial = {8'd0, depth_ff} << step_ff;
   assign req_ready = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_data.source_pixel = src_ff;
   assign push_data.shift = zero_ff ? 8'd0 : ((quot_ff > LIM) ? LIM : quot_ff);

   always_comb begin
      state_in = state_ff;
      src_in = src_ff;
      depth_in = depth_ff;
      rem_in = rem_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      zero_in = zero_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               src_in = req_data.source_pixel;
               depth_in = req_data.depth;
               state_in = F_MUL;
            end
         end
         F_MUL: begin
            // Depth at or below the focal depth (including zero) gives no shift.
            zero_in = (depth_ff <= focal_depth);
            rem_in = 24'(eye_distance * 16'(depth_ff - focal_depth));
            quot_in = 8'd0;
            step_in = 3'd7;
            state_in = F_DIV;
         end
         F_DIV: begin
            if (rem_ff >= trial) begin
               rem_in = rem_ff - trial;
               quot_in[step_ff] = 1'b1;
            end
            if (step_ff == 3'd0 || zero_ff) state_in = F_PUSH;
            else step_in = step_ff - 3'd1;
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= F_IDLE;
      else state_ff <= state_in;
      src_ff <= src_in;
      depth_ff <= depth_in;
      rem_ff <= rem_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end
endmodule

>>> design/srs_fifo.sv
// Two-entry queue between the front and back parts.
// Uses srs_pkg for the work item type.
`timescale 1ns / 1ps
module srs_fifo
   import srs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  work_type push_data,
   output logic     pop_valid,
   input  logic     pop_ready,
   output work_type pop_data
);
   work_type   entry_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data = entry_ff[rptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wptr_in = do_push ? ~wptr_ff : wptr_ff;
      rptr_in = do_pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) entry_ff[wptr_ff] <= push_data;
   end
endmodule

>>> design/srs_back.sv
// Back part: pending byte store, row position and the output register.
// Uses srs_pkg for the work item and result types.
`timescale 1ns / 1ps
module srs_back
   import srs_pkg::*;
#(
   parameter int MAX_SHIFT = 255,
   parameter int MAX_ROW_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  work_type    pop_data,
   input  logic [10:0] row_width,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);
   localparam int STORE = MAX_SHIFT + 1;
   localparam int SW = $clog2(STORE);
   localparam int CW = $clog2(MAX_ROW_WIDTH);
   localparam int XW = CW + 12;
   localparam int TW = SW + 9;
   localparam logic B_IDLE = 1'b0;
   localparam logic B_WR   = 1'b1;

   logic [7:0]    mem [STORE];
   logic [7:0]    rdata_ff;
   logic [STORE-1:0] valid_ff, valid_in;
   logic          state_ff, state_in;
   logic [CW-1:0] column_ff, column_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          load;
   logic [7:0]    val;
   logic [XW-1:0] width_eff, col_x, shift_x;
   logic          last, queue_it;
   logic [TW-1:0] tsum;
   logic [SW-1:0] target;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign load = (state_ff == B_WR) && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = load;

   always_comb begin
      if (row_width == 11'd0) width_eff = XW'(1);
      else if (XW'(row_width) > XW'(MAX_ROW_WIDTH)) width_eff = XW'(MAX_ROW_WIDTH);
      else width_eff = XW'(row_width);
      col_x = XW'(column_ff);
      shift_x = XW'(pop_data.shift);
      last = (col_x + XW'(1)) >= width_eff;
      queue_it = (pop_data.shift != 8'd0) && ((col_x + shift_x) < width_eff);
      val = valid_ff[slot_ff] ? rdata_ff : pop_data.source_pixel;
      // The shift never exceeds MAX_SHIFT, so one subtract wraps the slot.
      tsum = TW'(slot_ff) + TW'(pop_data.shift);
      if (tsum >= TW'(STORE)) tsum = tsum - TW'(STORE);
      target = tsum[SW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      column_in = column_ff;
      slot_in = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) state_in = B_WR;
         end
         B_WR: begin
            if (load) begin
               state_in = B_IDLE;
               rsp_valid_in = 1'b1;
               rsp_data_in.pixel = val;
               rsp_data_in.row_end = last;
               valid_in[slot_ff] = 1'b0;
               if (queue_it) valid_in[target] = 1'b1;
               if (last) begin
                  valid_in = '0;
                  column_in = '0;
                  slot_in = '0;
               end else begin
                  column_in = column_ff + CW'(1);
                  slot_in = (slot_ff == SW'(STORE - 1)) ? '0 : slot_ff + SW'(1);
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= '0;
         column_ff <= '0;
         slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         column_ff <= column_in;
         slot_ff <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[slot_ff];
      if (load && queue_it) mem[target] <= val;
   end

`ifndef SYNTH
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      column_ff < CW'(MAX_ROW_WIDTH - 1) || column_ff == CW'(MAX_ROW_WIDTH - 1))
      else $error("column out of range");
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      (load && last) |=> (column_ff == '0 && slot_ff == '0 && valid_ff == '0))
      else $error("row end did not restart the row");
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("result lost");
   a_target_differs: assert property (@(posedge clock) disable iff (reset)
      (load && queue_it) |-> target != slot_ff)
      else $error("pending byte written to its own slot");
`endif
endmodule

>>> design/stereogram_row_shifter.sv
// Stereogram row shifter: turns a raster stream of pattern bytes and depths
// into stereogram bytes. Top level; uses srs_pkg, srs_front, srs_fifo and
// srs_back.
//
// Usage: pixels enter on req_ in raster order, one transfer per pixel, and
// each gives exactly one result on rsp_ with the output byte and a flag on
// the last pixel of a row. Registers are written on csr_ (index 0 eye
// distance, 1 focal depth, 2 row width); the user must write them only
// while the block is idle, as the block itself does not enforce it.
// Flow: the front holds one pixel through its multiply and 8-step
// division of the shift and takes no new pixel until it is pushed on. The
// back reads and updates the pending byte store one item at a time, and a
// two-entry queue lets front and back stall independently.
// Reset: registers return to 64, 128 and 640, the row starts at column 0
// and no byte is pending. When rsp_ready is low the result waits in the
// output register; the front keeps taking pixels until the queue fills.
`timescale 1ns / 1ps
module stereogram_row_shifter
   import srs_pkg::*;
#(
   parameter int MAX_SHIFT = 255,
   parameter int MAX_ROW_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [7:0]  eye_ff;
   logic [15:0] focal_ff;
   logic [10:0] width_ff;
   logic        f_valid, f_ready, b_valid, b_ready;
   work_type    f_data, b_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff <= 8'd64;
         focal_ff <= 16'd128;
         width_ff <= 11'd640;
      end else if (csr_valid) begin
         case (csr_index)
            REG_EYE_DISTANCE: eye_ff <= csr_data[7:0];
            REG_FOCAL_DEPTH:  focal_ff <= csr_data;
            REG_ROW_WIDTH:    width_ff <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   srs_front #(.MAX_SHIFT(MAX_SHIFT)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .eye_distance(eye_ff), .focal_depth(focal_ff),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data)
   );

   srs_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
   );

   srs_back #(.MAX_SHIFT(MAX_SHIFT), .MAX_ROW_WIDTH(MAX_ROW_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data),
      .row_width(width_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
